// File: hdl/circular_sequence_store_core_macros.svh
// ----------------------------------------------------------------------------
// circular sequence store assertion macros
// shared concurrent assertion forms, clocked on clk_i, disabled in reset
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_SEQUENCE_STORE_CORE_MACROS_SVH
`define CIRCULAR_SEQUENCE_STORE_CORE_MACROS_SVH

// same-cycle implication
`define CSST_ASSERT_IMPL(label, cond, conseq) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (conseq)) \
    else $error("%m: assertion failed");

// next-cycle implication
`define CSST_ASSERT_NEXT(label, cond, conseq) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (conseq)) \
    else $error("%m: assertion failed");

`endif

// File: hdl/csst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csst_pkg
// sizes, codes and shared types of the circular sequence store
// ----------------------------------------------------------------------------
package csst_pkg;

  localparam int DEPTH     = 32;
  localparam int WORD_BITS = 32;

  // fixed field widths of the channels
  localparam int ACT_W   = 3;
  localparam int POS_W   = 6;
  localparam int VAL_W   = 32;
  localparam int ROT_W   = 16;
  localparam int CNTO_W  = 6;

  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int DSTEP_W = $clog2(ROT_W + 1);

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 3'd0,
    ACT_DELETE = 3'd1,
    ACT_READ   = 3'd2,
    ACT_WRITE  = 3'd3,
    ACT_ROTATE = 3'd4
  } act_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_WRITE,
    CELL_ROT
  } cell_op_e;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_op_e         op;
    logic [CMP_W-1:0] pos;
    logic [CMP_W-1:0] last;
    word_t            word;
  } cell_cmd_t;

  typedef struct packed {
    logic             start;
    logic [ROT_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] rem;
  } div_rsp_t;

endpackage

// File: hdl/csst_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csst channel interfaces
// command channel and result channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface csst_in_if;
  logic                              valid;
  logic                              ready;
  logic        [csst_pkg::ACT_W-1:0] action;
  logic        [csst_pkg::POS_W-1:0] position;
  logic        [csst_pkg::VAL_W-1:0] value;
  logic signed [csst_pkg::ROT_W-1:0] rotate_steps;

  modport source (output valid, action, position, value, rotate_steps, input ready);
  modport sink   (input valid, action, position, value, rotate_steps, output ready);
endinterface

interface csst_out_if;
  logic                         valid;
  logic                         ready;
  logic [csst_pkg::VAL_W-1:0]   read_value;
  logic [csst_pkg::CNTO_W-1:0]  entry_count;
  logic                         error;

  modport source (output valid, read_value, entry_count, error, input ready);
  modport sink   (input valid, read_value, entry_count, error, output ready);
endinterface

// File: hdl/csst_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csst_cell
// one storage slot of the chain, takes its own word, the command word, a neighbor or the head
// ----------------------------------------------------------------------------
module csst_cell (
  input  logic                        clk_i,
  input  logic [csst_pkg::CMP_W-1:0]  idx_i,
  input  csst_pkg::cell_cmd_t         cmd_i,
  input  csst_pkg::word_t             prev_i,
  input  csst_pkg::word_t             next_i,
  input  csst_pkg::word_t             head_i,
  output csst_pkg::word_t             word_o
);
  import csst_pkg::*;

  word_t word_q, word_d;

  always_comb begin
    word_d = word_q;
    unique case (cmd_i.op)
      CELL_INSERT: begin
        if (idx_i == cmd_i.pos) word_d = cmd_i.word;
        else if (idx_i > cmd_i.pos) word_d = prev_i;
      end
      CELL_DELETE: begin
        if (idx_i >= cmd_i.pos) word_d = next_i;
      end
      CELL_WRITE: begin
        if (idx_i == cmd_i.pos) word_d = cmd_i.word;
      end
      // one step forward inside the occupied range, head wraps to the tail
      CELL_ROT: begin
        if (idx_i == cmd_i.last) word_d = head_i;
        else if (idx_i < cmd_i.last) word_d = next_i;
      end
      default: word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

// File: hdl/csst_modred.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csst_modred
// restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
module csst_modred (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  csst_pkg::div_req_t  req_i,
  output csst_pkg::div_rsp_t  rsp_o
);
  import csst_pkg::*;

  logic [ROT_W-1:0]   dvd_q, dvd_d;
  logic [CNT_W-1:0]   dsr_q, dsr_d;
  logic [CNT_W-1:0]   rem_q, rem_d;
  logic [DSTEP_W-1:0] step_q, step_d;
  logic               done_q, done_d;
  logic [CNT_W:0]     trial;

  always_comb begin
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    step_d = step_q;
    done_d = 1'b0;
    trial  = {rem_q, dvd_q[ROT_W-1]};
    if (req_i.start) begin
      dvd_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
      rem_d  = '0;
      step_d = DSTEP_W'(ROT_W);
    end else if (step_q != '0) begin
      if (trial >= {1'b0, dsr_q}) rem_d = CNT_W'(trial - {1'b0, dsr_q});
      else rem_d = CNT_W'(trial);
      dvd_d  = {dvd_q[ROT_W-2:0], 1'b0};
      step_d = step_q - DSTEP_W'(1);
      done_d = (step_q == DSTEP_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

// File: hdl/circular_sequence_store_core.sv
`timescale 1ns / 1ps
// insert, delete, read and write: the result is registered and shown in the cycle after acceptance;
// one such command per cycle while the result register drains
// rotate: accepted, then the remainder of the steps by the count is found, then the chain
// rotates by the reduced amount (up to count-1); the cell chain moves one slot per cycle
// reset clears the count and the control state; stored words stay undefined until written
// ----------------------------------------------------------------------------
// circular_sequence_store_core
// circular sequence store built as a chain of word cells
// ----------------------------------------------------------------------------
`include "circular_sequence_store_core_macros.svh"

module circular_sequence_store_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  csst_in_if.sink    in_i,
  csst_out_if.source out_o
);
  import csst_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_ROT  = 3'b100
  } state_e;

  state_e           st_q, st_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] k_q, k_d;
  logic             neg_q, neg_d;

  logic             out_valid_q, out_valid_d;
  logic [VAL_W-1:0] rd_q, rd_d;
  logic [CNTO_W-1:0] cnt_out_q, cnt_out_d;
  logic             err_q, err_d;
  logic             res_load;

  logic             in_ready, in_acc;
  logic [CMP_W-1:0] pos_ext, cnt_ext;
  logic             full;
  word_t            rd_word;
  logic [CNT_W-1:0] m_rem;

  cell_cmd_t        cmd;
  div_req_t         div_req;
  div_rsp_t         div_rsp;
  word_t            cell_w [DEPTH];

  assign in_ready = (st_q == ST_IDLE) && (!out_valid_q || out_o.ready);
  assign in_acc   = in_i.valid && in_ready;
  assign pos_ext  = CMP_W'(in_i.position);
  assign cnt_ext  = CMP_W'(count_q);
  assign full     = (count_q == CNT_W'(DEPTH));
  assign m_rem    = div_rsp.rem;

  // read select over the cells
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (CMP_W'(i) == pos_ext) rd_word = cell_w[i];
    end
  end

  always_comb begin
    st_d      = st_q;
    count_d   = count_q;
    k_d       = k_q;
    neg_d     = neg_q;
    res_load  = 1'b0;
    rd_d      = '0;
    err_d     = 1'b0;
    cmd.op    = CELL_HOLD;
    cmd.pos   = pos_ext;
    cmd.last  = cnt_ext - CMP_W'(1);
    cmd.word  = WORD_BITS'(in_i.value);
    div_req.start    = 1'b0;
    div_req.dividend = in_i.rotate_steps[ROT_W-1] ? ROT_W'(-in_i.rotate_steps)
                                                  : ROT_W'(in_i.rotate_steps);
    div_req.divisor  = count_q;

    unique case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          res_load = 1'b1;
          unique case (in_i.action)
            ACT_INSERT: begin
              if (full || pos_ext > cnt_ext) err_d = 1'b1;
              else begin
                cmd.op  = CELL_INSERT;
                count_d = count_q + CNT_W'(1);
              end
            end
            ACT_DELETE: begin
              if (pos_ext >= cnt_ext) err_d = 1'b1;
              else begin
                cmd.op  = CELL_DELETE;
                count_d = count_q - CNT_W'(1);
              end
            end
            ACT_READ: begin
              if (pos_ext >= cnt_ext) err_d = 1'b1;
              else rd_d = VAL_W'(rd_word);
            end
            ACT_WRITE: begin
              if (pos_ext >= cnt_ext) err_d = 1'b1;
              else cmd.op = CELL_WRITE;
            end
            ACT_ROTATE: begin
              if (count_q == '0) err_d = 1'b1;
              else begin
                // result comes after the rotation completes
                res_load      = 1'b0;
                div_req.start = 1'b1;
                neg_d         = in_i.rotate_steps[ROT_W-1];
                st_d          = ST_DIV;
              end
            end
            default: err_d = 1'b1;
          endcase
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          // backward rotation by m is forward by count - m
          if (neg_q && m_rem != '0) k_d = count_q - m_rem;
          else k_d = m_rem;
          st_d = ST_ROT;
        end
      end
      ST_ROT: begin
        if (k_q != '0) begin
          cmd.op = CELL_ROT;
          k_d    = k_q - CNT_W'(1);
        end else if (!out_valid_q || out_o.ready) begin
          res_load = 1'b1;
          st_d     = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
    cnt_out_d = CNTO_W'(count_d);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) out_valid_d = 1'b1;
    else if (out_o.ready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q   <= k_d;
    neg_q <= neg_d;
    if (res_load) begin
      rd_q      <= rd_d;
      cnt_out_q <= cnt_out_d;
      err_q     <= err_d;
    end
  end

  csst_modred u_modred (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    word_t prev_w, next_w;
    if (g == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_mid_prev
      assign prev_w = cell_w[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_mid_next
      assign next_w = cell_w[g+1];
    end
    csst_cell u_cell (
      .clk_i  (clk_i),
      .idx_i  (CMP_W'(g)),
      .cmd_i  (cmd),
      .prev_i (prev_w),
      .next_i (next_w),
      .head_i (cell_w[0]),
      .word_o (cell_w[g])
    );
  end

  assign in_i.ready        = in_ready;
  assign out_o.valid       = out_valid_q;
  assign out_o.read_value  = rd_q;
  assign out_o.entry_count = cnt_out_q;
  assign out_o.error       = err_q;

  // a rotation only runs on a non-empty store
  `CSST_ASSERT_IMPL(a_rot_nonempty, st_q != ST_IDLE, count_q != '0)
  // count moves only on an accepted beat
  `CSST_ASSERT_NEXT(a_cnt_hold, !in_acc, $stable(count_q))
  // each rotation cycle consumes one step
  `CSST_ASSERT_NEXT(a_rot_step, st_q == ST_ROT && k_q != '0, k_q == $past(k_q) - CNT_W'(1))
  // remainder done moves straight to the shift phase
  `CSST_ASSERT_NEXT(a_div_to_rot, st_q == ST_DIV && div_rsp.done, st_q == ST_ROT)

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the circular sequence store: a directed opening,
// then random command beats with random stalls on both channels, every
// result beat checked against a scoreboard that keeps its own copy of the list
// ----------------------------------------------------------------------------
module tb_top;
  import csst_pkg::*;

  typedef struct {
    logic [ACT_W-1:0]        action;
    logic [POS_W-1:0]        position;
    logic [VAL_W-1:0]        value;
    logic signed [ROT_W-1:0] rotate_steps;
  } store_cmd_t;

  typedef struct {
    logic [VAL_W-1:0]  read_value;
    logic [CNTO_W-1:0] entry_count;
    logic              error;
  } store_rsp_t;

  class store_scoreboard;
    word_t      words[DEPTH];
    int         fill;
    store_rsp_t expected_rsps[$];
    int         mismatches;
    int         commands;
    int         checked;
    int         rejected;
    int         rotations;
    int         peak_fill;

    function new();
      fill       = 0;
      mismatches = 0;
      commands   = 0;
      checked    = 0;
      rejected   = 0;
      rotations  = 0;
      peak_fill  = 0;
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 20) begin
        $display("[%0t] mismatch: %s", $realtime, msg);
      end
    endtask

    // update the list copy for one accepted command beat and queue its result
    function void note_command(store_cmd_t c);
      store_rsp_t r;
      word_t      moved[DEPTH];
      int         p;
      int         s;
      int         k;
      int         i;
      r.read_value = '0;
      r.error      = 1'b0;
      p = int'(c.position);
      case (c.action)
        ACT_INSERT: begin
          if (fill >= DEPTH || p > fill) begin
            r.error = 1'b1;
          end else begin
            for (i = fill; i > p; i--) words[i] = words[i-1];
            words[p] = c.value[WORD_BITS-1:0];
            fill++;
          end
        end
        ACT_DELETE: begin
          if (p >= fill) begin
            r.error = 1'b1;
          end else begin
            for (i = p; i + 1 < fill; i++) words[i] = words[i+1];
            fill--;
          end
        end
        ACT_READ: begin
          if (p >= fill) r.error = 1'b1;
          else r.read_value = VAL_W'(words[p]);
        end
        ACT_WRITE: begin
          if (p >= fill) r.error = 1'b1;
          else words[p] = c.value[WORD_BITS-1:0];
        end
        ACT_ROTATE: begin
          if (fill == 0) begin
            r.error = 1'b1;
          end else begin
            rotations++;
            s = int'(c.rotate_steps);
            if (s < 0) begin
              k = (-s) % fill;
              if (k != 0) k = fill - k;
            end else begin
              k = s % fill;
            end
            if (k != 0) begin
              for (i = 0; i < fill; i++) moved[i] = words[(i + k) % fill];
              for (i = 0; i < fill; i++) words[i] = moved[i];
            end
          end
        end
        default: r.error = 1'b1;
      endcase
      r.entry_count = CNTO_W'(fill);
      if (r.error) rejected++;
      if (fill > peak_fill) peak_fill = fill;
      commands++;
      expected_rsps.push_back(r);
    endfunction

    task check_result(store_rsp_t got);
      store_rsp_t want;
      if (expected_rsps.size() == 0) begin
        report_mismatch("result beat with nothing outstanding");
      end else begin
        want = expected_rsps.pop_front();
        checked++;
        if (got.read_value !== want.read_value)
          report_mismatch($sformatf("read_value %h, want %h", got.read_value,
                                    want.read_value));
        if (got.entry_count !== want.entry_count)
          report_mismatch($sformatf("entry_count %0d, want %0d", got.entry_count,
                                    want.entry_count));
        if (got.error !== want.error)
          report_mismatch($sformatf("error %b, want %b", got.error, want.error));
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic no_idle;

  csst_in_if  in_if ();
  csst_out_if out_if ();

  store_scoreboard sb = new();

  circular_sequence_store_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("FAILURE");
    $finish;
  end

  // result side back-pressure
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready <= no_idle || ($urandom_range(0, 99) >= 25);
    end
  end

  always @(posedge clk_i) begin
    store_rsp_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.read_value  = out_if.read_value;
      got.entry_count = out_if.entry_count;
      got.error       = out_if.error;
      sb.check_result(got);
    end
  end

  function automatic store_cmd_t mk_cmd(logic [ACT_W-1:0] action, int position,
                                        logic [VAL_W-1:0] value, int steps);
    store_cmd_t c;
    c.action       = action;
    c.position     = POS_W'(position);
    c.value        = value;
    c.rotate_steps = ROT_W'(steps);
    return c;
  endfunction

  // mostly well-formed commands around the current fill, some noise
  function automatic store_cmd_t random_cmd(bit filling, int fill);
    store_cmd_t c;
    int         roll;
    int         top;
    int         m;
    c.value = $urandom();
    roll = $urandom_range(0, 99);
    if (roll < 5) c.value = '0;
    else if (roll < 10) c.value = '1;
    c.rotate_steps = ROT_W'($urandom());
    c.position     = POS_W'($urandom());
    c.action       = ACT_W'($urandom_range(0, 7));
    if ($urandom_range(0, 99) < 8) return c;
    roll = $urandom_range(0, 99);
    if (filling) begin
      if (roll < 55) c.action = ACT_INSERT;
      else if (roll < 65) c.action = ACT_DELETE;
      else if (roll < 77) c.action = ACT_READ;
      else if (roll < 89) c.action = ACT_WRITE;
      else c.action = ACT_ROTATE;
    end else begin
      if (roll < 10) c.action = ACT_INSERT;
      else if (roll < 55) c.action = ACT_DELETE;
      else if (roll < 70) c.action = ACT_READ;
      else if (roll < 85) c.action = ACT_WRITE;
      else c.action = ACT_ROTATE;
    end
    top  = (c.action == ACT_INSERT) ? fill : fill - 1;
    roll = $urandom_range(0, 99);
    if (roll < 5) c.position = POS_W'(top + 1 + $urandom_range(0, 1));
    else if (top < 0) c.position = '0;
    else if (roll < 15) c.position = '0;
    else if (roll < 25) c.position = POS_W'(top);
    else c.position = POS_W'($urandom_range(0, top));
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      c.rotate_steps = ROT_W'(int'($urandom_range(0, 80)) - 40);
    end else if (roll < 50) begin
      m = fill * int'($urandom_range(0, 20));
      c.rotate_steps = ROT_W'(($urandom_range(0, 1) != 0) ? -m : m);
    end
    return c;
  endfunction

  // one command beat, with random gaps before valid rises
  task send_cmd(store_cmd_t c);
    @(negedge clk_i);
    while (!no_idle && $urandom_range(0, 99) < 25) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.action       <= c.action;
    in_if.position     <= c.position;
    in_if.value        <= c.value;
    in_if.rotate_steps <= c.rotate_steps;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_command(c);
  endtask

  initial begin
    store_cmd_t directed[$];
    int         n;
    rst_ni             = 1'b0;
    no_idle            = 1'b0;
    in_if.valid        = 1'b0;
    in_if.action       = '0;
    in_if.position     = '0;
    in_if.value        = '0;
    in_if.rotate_steps = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // empty store, edges of insert, reads, a write, rotation corner cases, deletes, illegal action codes
    directed.push_back(mk_cmd(ACT_ROTATE, 0, '0, 5));
    directed.push_back(mk_cmd(ACT_READ, 0, '0, 0));
    directed.push_back(mk_cmd(ACT_INSERT, 1, 32'h1111_1111, 0));
    directed.push_back(mk_cmd(ACT_INSERT, 0, 32'hffff_ffff, 0));
    directed.push_back(mk_cmd(ACT_INSERT, 1, 32'h0000_0000, 0));
    directed.push_back(mk_cmd(ACT_INSERT, 0, 32'ha5a5_a5a5, 0));
    directed.push_back(mk_cmd(ACT_INSERT, 2, 32'h1234_5678, 0));
    for (n = 0; n < 4; n++) directed.push_back(mk_cmd(ACT_READ, n, '0, 0));
    directed.push_back(mk_cmd(ACT_WRITE, 3, 32'h5a5a_5a5a, 0));
    directed.push_back(mk_cmd(ACT_ROTATE, 0, '0, 0));
    directed.push_back(mk_cmd(ACT_ROTATE, 0, '0, 4));
    directed.push_back(mk_cmd(ACT_ROTATE, 0, '0, -1));
    directed.push_back(mk_cmd(ACT_ROTATE, 0, '0, 32767));
    directed.push_back(mk_cmd(ACT_ROTATE, 0, '0, -32768));
    directed.push_back(mk_cmd(ACT_READ, 0, '0, 0));
    directed.push_back(mk_cmd(ACT_DELETE, 0, '0, 0));
    directed.push_back(mk_cmd(ACT_DELETE, 2, '0, 0));
    directed.push_back(mk_cmd(ACT_DELETE, 63, '0, 0));
    directed.push_back(mk_cmd(3'd5, 0, 32'hdead_beef, 1));
    directed.push_back(mk_cmd(3'd6, 0, 32'hdead_beef, 1));
    directed.push_back(mk_cmd(3'd7, 0, 32'hdead_beef, 1));
    directed.push_back(mk_cmd(ACT_WRITE, 2, 32'h0bad_0bad, 0));
    foreach (directed[i]) send_cmd(directed[i]);

    for (n = 0; n < 1600; n++) begin
      no_idle = (n >= 700 && n < 1000);
      send_cmd(random_cmd(((n / 150) % 2) == 0, sb.fill));
    end
    no_idle = 1'b0;
    @(negedge clk_i);
    in_if.valid <= 1'b0;

    while (sb.expected_rsps.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (sb.expected_rsps.size() != 0) sb.report_mismatch("results still outstanding");

    $display("run: %0d commands, %0d results checked, %0d rejected, %0d rotations",
             sb.commands, sb.checked, sb.rejected, sb.rotations);
    $display("run: peak fill %0d of %0d, %0d mismatches", sb.peak_fill, DEPTH,
             sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/csst_pkg.sv
hdl/csst_if.sv
hdl/csst_cell.sv
hdl/csst_modred.sv
hdl/circular_sequence_store_core.sv
dv/tb_top.sv
